// ----- rtl/ebs_pkg.sv -----
// ----------------------------------------------------------------------------
// Embedding bag sum package
// Request codes, register indexes and field widths shared by the block.
// ----------------------------------------------------------------------------
package ebs_pkg;

    localparam int ACTION_W = 2;
    localparam int TID_W    = 2;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 6;
    localparam int WORD_W   = 32;
    localparam int SUM_W    = 48;
    localparam int COLS_W   = 7;
    localparam int ROWS_W   = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLOSE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;

    localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd1024;

    typedef logic signed [SUM_W-1:0] sum_t;

endpackage

// ----- rtl/embedding_bag_sum_top.sv -----
// ----------------------------------------------------------------------------
// Embedding bag sum
// A table write or a skipped add does not raise busy. An add of an in-range row or
// a close holds busy through the issue and drain states, one column per cycle
// through the table and accumulator memories. A close gives its results through
// the issue and result registers, one each cycle. Reset clears control,
// accumulators (valid flags) and the bad flag at once; table contents stay
// undefined until written. Results cannot stall.
// ----------------------------------------------------------------------------
module embedding_bag_sum_top #(
    parameter int NUM_TABLES = 4,
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_COLS   = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ebs_pkg::ACTION_W-1:0]       action,
    input  logic [ebs_pkg::TID_W-1:0]          table_id,
    input  logic [ebs_pkg::ROW_W-1:0]          row,
    input  logic [ebs_pkg::COL_W-1:0]          col,
    input  logic signed [ebs_pkg::WORD_W-1:0]  word,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ebs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ebs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               result_valid,
    output logic [ebs_pkg::COL_W-1:0]          sum_col,
    output logic signed [ebs_pkg::SUM_W-1:0]   sum,
    output logic                               last,
    output logic                               bad_row
);
    import ebs_pkg::*;

    localparam longint unsigned DEPTH =
        longint'(NUM_TABLES) * longint'(MAX_ROWS) * longint'(MAX_COLS);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN} state_t;

    function automatic logic [ADDR_W-1:0] table_addr(input logic [TID_W-1:0] t,
                                                     input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] c);
        return (ADDR_W'(t) * ADDR_W'(MAX_ROWS) + ADDR_W'(r)) * ADDR_W'(MAX_COLS)
               + ADDR_W'(c);
    endfunction

    logic signed [WORD_W-1:0] tmem [DEPTH];
    logic signed [WORD_W-1:0] tmem_q;
    sum_t                     amem [MAX_COLS];
    sum_t                     amem_q;

    state_t               state_reg;
    logic                 op_add_reg;
    logic [TID_W-1:0]     tid_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     cnt_reg;
    logic [COLS_W-1:0]    ncols_reg;
    logic [COLS_W-1:0]    cols_reg;
    logic [ROWS_W-1:0]    rows_reg;
    logic                 bad_reg;
    logic                 p_valid_reg;
    logic [COL_W-1:0]     p_col_reg;
    logic                 p_last_reg;
    logic [MAX_COLS-1:0]  acc_vld_reg;
    logic                 busy_reg;

    logic                 accept;
    logic [COLS_W-1:0]    ncols;
    logic [ROWS_W-1:0]    rows_eff;
    logic                 add_bad;
    logic                 wr_ok;
    logic                 issue_last;
    sum_t                 acc_cur;
    logic signed [SUM_W:0] acc_wide;
    sum_t                 acc_next;
    logic                 acc_we;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;

    always_comb
    begin
        if (cols_reg == '0)
        begin
            ncols = COLS_W'(1);
        end
        else if (32'(cols_reg) > MAX_COLS)
        begin
            ncols = COLS_W'(MAX_COLS);
        end
        else
        begin
            ncols = cols_reg;
        end
    end

    assign rows_eff   = (rows_reg == '0) ? ROWS_W'(1) : rows_reg;
    assign add_bad    = (32'(table_id) >= NUM_TABLES) || (ROWS_W'(row) >= rows_eff)
                        || (32'(row) >= MAX_ROWS);
    assign wr_ok      = (32'(table_id) < NUM_TABLES) && (32'(row) < MAX_ROWS)
                        && (32'(col) < MAX_COLS);
    assign issue_last = (COLS_W'(cnt_reg) + COLS_W'(1)) == ncols_reg;

    assign acc_cur  = acc_vld_reg[p_col_reg[CIDX_W-1:0]] ? amem_q : sum_t'(0);
    assign acc_wide = {acc_cur[SUM_W-1], acc_cur}
                      + {{(SUM_W+1-WORD_W){tmem_q[WORD_W-1]}}, tmem_q};

    always_comb
    begin
        if (acc_wide[SUM_W] != acc_wide[SUM_W-1])
        begin
            acc_next = acc_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            acc_next = acc_wide[SUM_W-1:0];
        end
    end

    assign acc_we = p_valid_reg && op_add_reg;

    always_ff @(posedge clk)
    begin
        if (accept && action == ACT_WRITE && wr_ok)
        begin
            tmem[table_addr(table_id, row, col)] <= word;
        end
        tmem_q <= tmem[table_addr(tid_reg, row_reg, cnt_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            amem[p_col_reg[CIDX_W-1:0]] <= acc_next;
        end
        amem_q <= amem[cnt_reg[CIDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            busy_reg     <= 1'b0;
            op_add_reg   <= 1'b0;
            cnt_reg      <= '0;
            ncols_reg    <= COLS_RESET;
            cols_reg     <= COLS_RESET;
            rows_reg     <= ROWS_RESET;
            bad_reg      <= 1'b0;
            p_valid_reg  <= 1'b0;
            p_col_reg    <= '0;
            p_last_reg   <= 1'b0;
            acc_vld_reg  <= '0;
            result_valid <= 1'b0;
            sum_col      <= '0;
            sum          <= '0;
            last         <= 1'b0;
            bad_row      <= 1'b0;
            tid_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            result_valid <= 1'b0;
            p_valid_reg  <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_COLS)
                begin
                    cols_reg <= cfg_data[COLS_W-1:0];
                end
                else if (cfg_index == CFG_ROWS)
                begin
                    rows_reg <= cfg_data[ROWS_W-1:0];
                end
            end

            if (p_valid_reg)
            begin
                if (op_add_reg)
                begin
                    acc_vld_reg[p_col_reg[CIDX_W-1:0]] <= 1'b1;
                end
                else
                begin
                    result_valid <= 1'b1;
                    sum_col      <= p_col_reg;
                    sum          <= acc_cur;
                    last         <= p_last_reg;
                    bad_row      <= bad_reg;
                    if (p_last_reg)
                    begin
                        acc_vld_reg <= '0;
                        bad_reg     <= 1'b0;
                    end
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        tid_reg   <= table_id;
                        row_reg   <= row;
                        cnt_reg   <= '0;
                        ncols_reg <= ncols;
                        case (action)
                            ACT_ADD:
                            begin
                                if (add_bad)
                                begin
                                    bad_reg <= 1'b1;
                                end
                                else
                                begin
                                    op_add_reg <= 1'b1;
                                    state_reg  <= S_ISSUE;
                                    busy_reg   <= 1'b1;
                                end
                            end
                            ACT_CLOSE:
                            begin
                                op_add_reg <= 1'b0;
                                state_reg  <= S_ISSUE;
                                busy_reg   <= 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_ISSUE:
                begin
                    p_valid_reg <= 1'b1;
                    p_col_reg   <= cnt_reg;
                    p_last_reg  <= issue_last;
                    cnt_reg     <= cnt_reg + COL_W'(1);
                    if (issue_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Embedding bag sum testbench
// Loads table rows, builds bags of row adds and closes them under several
// column and row counts. A scoreboard predicts every column sum of every
// close and checks the result strobes in order.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ebs_pkg::*;

    localparam int NUM_TABLES = 4;
    localparam int MAX_ROWS   = 1024;
    localparam int MAX_COLS   = 64;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = MAX_COLS + 8;
    localparam int PHASE_ITEMS  = 70;

    typedef struct {
        logic [COL_W-1:0] sum_col;
        sum_t             sum;
        logic             last;
        logic             bad;
    } sum_rec_t;

    class bag_scoreboard;
        logic signed [WORD_W-1:0] store_words [int];
        bit [MAX_COLS-1:0]        loaded_mask [NUM_TABLES * MAX_ROWS];
        sum_t                     col_sums [MAX_COLS] = '{default: '0};
        bit                       bad_flag;
        logic [COLS_W-1:0]        cols_reg = COLS_RESET;
        logic [ROWS_W-1:0]        rows_reg = ROWS_RESET;
        sum_rec_t                 expected_sums [$];
        int                       errors;

        function int active_cols();
            int v;
            v = int'(cols_reg);
            if (v < 1)
                return 1;
            if (v > MAX_COLS)
                return MAX_COLS;
            return v;
        endfunction

        function int active_rows();
            int v;
            v = int'(rows_reg);
            if (v < 1)
                return 1;
            if (v > MAX_ROWS)
                return MAX_ROWS;
            return v;
        endfunction

        function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == CFG_COLS)
                cols_reg = d[COLS_W-1:0];
            else
                rows_reg = d[ROWS_W-1:0];
        endfunction

        function sum_t add_clipped(sum_t a, logic signed [WORD_W-1:0] w);
            longint t;
            t = longint'(a) + longint'(w);
            if (t > SUM_HI)
                return sum_t'(SUM_HI);
            if (t < SUM_LO)
                return sum_t'(SUM_LO);
            return sum_t'(t);
        endfunction

        function void note_request(logic [ACTION_W-1:0] a, logic [TID_W-1:0] t,
                                   logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                   logic signed [WORD_W-1:0] w);
            int        ncols;
            int        nrows;
            sum_rec_t  e;
            ncols = active_cols();
            nrows = active_rows();
            case (a)
                ACT_WRITE:
                begin
                    store_words[int'({t, r, c})] = w;
                    loaded_mask[int'({t, r})][c] = 1'b1;
                end
                ACT_ADD:
                begin
                    if (t >= NUM_TABLES || r >= nrows)
                        bad_flag = 1'b1;
                    else
                        for (int i = 0; i < ncols; i++)
                            col_sums[i] = add_clipped(col_sums[i],
                                store_words[int'({t, r, i[COL_W-1:0]})]);
                end
                ACT_CLOSE:
                begin
                    for (int i = 0; i < ncols; i++)
                    begin
                        e.sum_col = i[COL_W-1:0];
                        e.sum     = col_sums[i];
                        e.last    = (i == ncols - 1);
                        e.bad     = bad_flag;
                        expected_sums.push_back(e);
                    end
                    foreach (col_sums[i])
                        col_sums[i] = '0;
                    bad_flag = 1'b0;
                end
                default:
                    ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("mismatch: %s", msg);
        endtask

        task check_result(logic [COL_W-1:0] ci, sum_t s, logic l, logic b);
            sum_rec_t e;
            if (expected_sums.size() == 0)
            begin
                report($sformatf("result for column %0d with nothing expected", ci));
                return;
            end
            e = expected_sums.pop_front();
            if (ci !== e.sum_col)
                report($sformatf("sum_col %0d, expected %0d", ci, e.sum_col));
            if (s !== e.sum)
                report($sformatf("column %0d sum %0d, expected %0d", e.sum_col, s, e.sum));
            if (l !== e.last)
                report($sformatf("column %0d last %b, expected %b", e.sum_col, l, e.last));
            if (b !== e.bad)
                report($sformatf("column %0d bad_row %b, expected %b", e.sum_col, b, e.bad));
        endtask
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [ACTION_W-1:0]          action = '0;
    logic [TID_W-1:0]             table_id = '0;
    logic [ROW_W-1:0]             row = '0;
    logic [COL_W-1:0]             col = '0;
    logic signed [WORD_W-1:0]     word = '0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         result_valid;
    logic [COL_W-1:0]             sum_col;
    logic signed [SUM_W-1:0]      sum;
    logic                         last;
    logic                         bad_row;

    bag_scoreboard sb = new();
    int            idle_pct;
    int            request_count;
    int            cycle_count;
    int            hot_keys [$];

    embedding_bag_sum_top #(
        .NUM_TABLES (NUM_TABLES),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .table_id     (table_id),
        .row          (row),
        .col          (col),
        .word         (word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .sum_col      (sum_col),
        .sum          (sum),
        .last         (last),
        .bad_row      (bad_row)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(sum_col, sum, last, bad_row);
    end

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [ACTION_W-1:0] a, input logic [TID_W-1:0] t,
                                input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                input logic signed [WORD_W-1:0] w);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        action   <= a;
        table_id <= t;
        row      <= r;
        col      <= c;
        word     <= w;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(a, t, r, c, w);
        if (a != ACT_UNUSED)
            request_count++;
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] cols_data,
                                  input logic [CFG_DATA_W-1:0] rows_data);
        start <= 1'b0;
        while (sb.expected_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_COLS;
        cfg_data  <= cols_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_config(CFG_COLS, cols_data);
        cfg_index <= CFG_ROWS;
        cfg_data  <= rows_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_config(CFG_ROWS, rows_data);
        cfg_valid <= 1'b0;
    endtask

    // Picks an in-range row and writes whatever columns in use it still lacks,
    // so that an add never reads a table word that was never written.
    task automatic ready_row(input int nrows, input int ncols, output int key);
        int cands [$];
        foreach (hot_keys[i])
            if ((hot_keys[i] % MAX_ROWS) < nrows)
                cands.push_back(hot_keys[i]);
        if (cands.size() == 0 || $urandom_range(0, 99) < 5)
        begin
            key = $urandom_range(0, NUM_TABLES - 1) * MAX_ROWS + $urandom_range(0, nrows - 1);
            hot_keys.push_back(key);
        end
        else
            key = cands[$urandom_range(0, cands.size() - 1)];
        for (int c = 0; c < ncols; c++)
            if (!sb.loaded_mask[key][c])
                send_request(ACT_WRITE, key[11:10], key[9:0], COL_W'(c), rand_word());
    endtask

    task automatic random_bag();
        int n_adds;
        int ncols;
        int nrows;
        int key;
        ncols  = sb.active_cols();
        nrows  = sb.active_rows();
        n_adds = $urandom_range(0, 4);
        repeat (n_adds)
        begin
            if (nrows < MAX_ROWS && $urandom_range(0, 99) < 20)
                send_request(ACT_ADD, TID_W'($urandom),
                             ROW_W'($urandom_range(nrows, MAX_ROWS - 1)),
                             COL_W'($urandom), $urandom);
            else
            begin
                ready_row(nrows, ncols, key);
                send_request(ACT_ADD, key[11:10], key[9:0], COL_W'($urandom), $urandom);
            end
            if ($urandom_range(0, 99) < 10)
                send_request(ACT_WRITE, TID_W'($urandom), ROW_W'($urandom),
                             COL_W'($urandom), rand_word());
            if ($urandom_range(0, 99) < 4)
                send_request(ACT_UNUSED, TID_W'($urandom), ROW_W'($urandom),
                             COL_W'($urandom), $urandom);
        end
        send_request(ACT_CLOSE, TID_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
                     $urandom);
    endtask

    initial
    begin
        int                    phase_start;
        int                    idle_mode;
        logic [CFG_DATA_W-1:0] cdat;
        logic [CFG_DATA_W-1:0] rdat;

        idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ACT_CLOSE, 2'd0, 10'd0, 6'd0, 32'sd0);
        send_request(ACT_UNUSED, 2'd3, 10'd1023, 6'd63, -32'sd1);

        apply_settings({4'hF, 7'd4}, 11'd1024);
        send_request(ACT_WRITE, 2'd3, 10'd1023, 6'd0, 32'sh7FFF_FFFF);
        send_request(ACT_WRITE, 2'd3, 10'd1023, 6'd1, 32'sh8000_0000);
        send_request(ACT_WRITE, 2'd3, 10'd1023, 6'd2, -32'sd1);
        send_request(ACT_WRITE, 2'd3, 10'd1023, 6'd3, 32'sd0);
        send_request(ACT_WRITE, 2'd0, 10'd0, 6'd0, 32'sd1);
        send_request(ACT_WRITE, 2'd0, 10'd0, 6'd1, -32'sd2);
        send_request(ACT_WRITE, 2'd0, 10'd0, 6'd2, 32'sh5555_5555);
        send_request(ACT_WRITE, 2'd0, 10'd0, 6'd3, 32'shAAAA_AAAA);
        send_request(ACT_ADD, 2'd3, 10'd1023, 6'd63, -32'sd1);
        send_request(ACT_ADD, 2'd0, 10'd0, 6'd0, 32'sd0);
        send_request(ACT_UNUSED, 2'd1, 10'd5, 6'd5, 32'sd5);
        send_request(ACT_CLOSE, 2'd3, 10'd1023, 6'd63, -32'sd1);

        apply_settings(11'd4, 11'd0);
        send_request(ACT_ADD, 2'd0, 10'd0, 6'd0, 32'sd0);
        send_request(ACT_ADD, 2'd3, 10'd1023, 6'd0, 32'sd0);
        send_request(ACT_CLOSE, 2'd0, 10'd0, 6'd0, 32'sd0);
        send_request(ACT_CLOSE, 2'd0, 10'd0, 6'd0, 32'sd0);

        send_request(ACT_ADD, 2'd0, 10'd0, 6'd0, 32'sd0);
        apply_settings(11'd2, 11'd0);
        send_request(ACT_ADD, 2'd0, 10'd0, 6'd0, 32'sd0);
        apply_settings(11'h07F, 11'h7FF);
        send_request(ACT_CLOSE, 2'd0, 10'd0, 6'd0, 32'sd0);

        apply_settings(11'd0, 11'd1024);
        send_request(ACT_ADD, 2'd3, 10'd1023, 6'd0, 32'sd0);
        send_request(ACT_CLOSE, 2'd0, 10'd0, 6'd0, 32'sd0);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    cdat = 11'd1;
                    rdat = 11'd1;
                    idle_mode = 0;
                end
                1:
                begin
                    cdat = 11'd64;
                    rdat = 11'd1024;
                    idle_mode = 85;
                end
                2:
                begin
                    cdat = CFG_DATA_W'($urandom_range(0, 2047));
                    rdat = CFG_DATA_W'($urandom_range(0, 2047));
                    idle_mode = 12;
                end
                default:
                begin
                    cdat = CFG_DATA_W'($urandom_range(1, 16));
                    rdat = CFG_DATA_W'($urandom_range(1, 64));
                    idle_mode = -1;
                end
            endcase
            apply_settings(cdat, rdat);
            phase_start = request_count;
            while (request_count - phase_start < PHASE_ITEMS)
            begin
                if (idle_mode >= 0)
                    idle_pct = idle_mode;
                else
                    case ($urandom_range(0, 2))
                        0: idle_pct = 0;
                        1: idle_pct = 12;
                        default: idle_pct = 85;
                    endcase
                random_bag();
            end
        end

        start <= 1'b0;
        while (sb.expected_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.expected_sums.size() != 0)
            sb.report("expected results left over at the end");
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
